[rtl/core/sxt_pkg.sv]
// Shared types, codes and constants for the s-expression tokenizer.
package sxt_pkg;

  localparam int unsigned LenW = 16;
  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [LenW-1:0] MaxLenReset = 16'd256;

  localparam logic [2:0] KIND_BEGIN      = 3'd0;
  localparam logic [2:0] KIND_END        = 3'd1;
  localparam logic [2:0] KIND_STRING_END = 3'd2;
  localparam logic [2:0] KIND_VALUE_END  = 3'd3;
  localparam logic [2:0] KIND_CONTENT    = 3'd4;
  localparam logic [2:0] KIND_EOI_ERROR  = 3'd5;

  localparam logic [1:0] MODE_SKIP   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_VALUE  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [2:0]      kind;
    logic [7:0]      content_byte;
    logic [LenW-1:0] token_length;
    logic            last;
  } sxt_res_t;

  typedef struct packed {
    logic     v0;
    logic     v1;
    sxt_res_t r0;
    sxt_res_t r1;
  } sxt_push_t;

endpackage

[rtl/core/sxt_if.sv]
// Handshake interfaces for the input word channel and the result word channel.
interface sxt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface sxt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  content_byte;
  logic [15:0] token_length;
  logic        last;

  modport source (output valid, output kind, output content_byte, output token_length,
                  output last, input ready);
  modport sink (input valid, input kind, input content_byte, input token_length,
                input last, output ready);
endinterface

[rtl/core/sxt_step.sv]
// Tokenizer mode and length state, and per-word event decode.
module sxt_step import sxt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            end_of_input,
  input  logic [LenW-1:0] max_len,
  output sxt_push_t       push
);

  logic [1:0]      mode_r, mode_nxt;
  logic [LenW-1:0] count_r, count_nxt;
  logic [LenW-1:0] limit;
  logic            blank, delim, keep, keep_first;
  sxt_res_t        r0, r1;
  logic            v0, v1;

  assign limit      = (max_len == '0) ? '0 : max_len - LenW'(1);
  assign keep       = count_r < limit;
  assign keep_first = limit != '0;
  assign blank      = (data_byte == CH_SPACE) || (data_byte == CH_CR) ||
                      (data_byte == CH_LF) || (data_byte == CH_TAB);
  assign delim      = blank || (data_byte == CH_OPEN) || (data_byte == CH_CLOSE) ||
                      (data_byte == CH_QUOTE);

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;
    if (accept) begin
      if (end_of_input) begin
        v0 = 1'b1;
        case (mode_r)
          MODE_STRING: begin
            r0.kind = KIND_STRING_END;
            r0.token_length = count_r;
          end
          MODE_VALUE: begin
            r0.kind = KIND_VALUE_END;
            r0.token_length = count_r;
          end
          default: r0.kind = KIND_EOI_ERROR;
        endcase
        mode_nxt  = MODE_SKIP;
        count_nxt = '0;
      end else if (mode_r == MODE_STRING) begin
        if (data_byte == CH_QUOTE) begin
          v0 = 1'b1;
          r0.kind = KIND_STRING_END;
          r0.token_length = count_r;
          mode_nxt  = MODE_SKIP;
          count_nxt = '0;
        end else if (keep) begin
          v0 = 1'b1;
          r0.kind = KIND_CONTENT;
          r0.content_byte = data_byte;
          count_nxt = count_r + LenW'(1);
        end
      end else if (mode_r == MODE_VALUE) begin
        if (delim) begin
          v0 = 1'b1;
          r0.kind = KIND_VALUE_END;
          r0.token_length = count_r;
          mode_nxt  = MODE_SKIP;
          count_nxt = '0;
          if (data_byte == CH_OPEN) begin
            v1 = 1'b1;
            r1.kind = KIND_BEGIN;
          end else if (data_byte == CH_CLOSE) begin
            v1 = 1'b1;
            r1.kind = KIND_END;
          end else if (data_byte == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
          end
        end else if (keep) begin
          v0 = 1'b1;
          r0.kind = KIND_CONTENT;
          r0.content_byte = data_byte;
          count_nxt = count_r + LenW'(1);
        end
      end else begin
        mode_nxt = MODE_SKIP;
        if (blank) begin
          mode_nxt = MODE_SKIP;
        end else if (data_byte == CH_OPEN) begin
          v0 = 1'b1;
          r0.kind = KIND_BEGIN;
        end else if (data_byte == CH_CLOSE) begin
          v0 = 1'b1;
          r0.kind = KIND_END;
        end else if (data_byte == CH_QUOTE) begin
          mode_nxt  = MODE_STRING;
          count_nxt = '0;
        end else begin
          mode_nxt  = MODE_VALUE;
          count_nxt = '0;
          if (keep_first) begin
            v0 = 1'b1;
            r0.kind = KIND_CONTENT;
            r0.content_byte = data_byte;
            count_nxt = LenW'(1);
          end
        end
      end
      if (v1) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SKIP;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  assign push.v0 = v0;
  assign push.v1 = v1;
  assign push.r0 = r0;
  assign push.r1 = r1;

endmodule

[rtl/core/sxt_outq.sv]
// Result word queue taking up to two words per cycle and handing out one.
module sxt_outq import sxt_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sxt_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output sxt_res_t  out_word
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  sxt_res_t        mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_1;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign wr_1      = inc(wr_r);
  assign room      = cnt_r <= RoomMax;
  assign out_valid = cnt_r != '0;
  assign out_word  = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    if (n_push == 2'd1) begin
      wr_nxt = wr_1;
    end else if (n_push == 2'd2) begin
      wr_nxt = inc(wr_1);
    end
    rd_nxt  = pop ? inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/sexpr_tokenizer.sv]
// Top level of the s-expression tokenizer.
// Results go from the combinational step decode into the registered queue.
// Throughput: one input word per cycle while each yields at most one result and
// results are taken; otherwise the one-word result port sets the rate.
// Reset: synchronous, active low; clears mode, length count and queue, and sets
// max_len_r to 256.
module sexpr_tokenizer import sxt_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [LenW-1:0] cfg_wdata,
  sxt_in_if.sink          in_ch,
  sxt_out_if.source       out_ch
);

  logic [LenW-1:0] max_len_r;
  logic            room, accept;
  sxt_push_t       push;
  sxt_res_t        word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  sxt_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .max_len      (max_len_r),
    .push         (push)
  );

  sxt_outq #(.Depth(QueueDepth)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (word)
  );

  assign out_ch.kind         = word.kind;
  assign out_ch.content_byte = word.content_byte;
  assign out_ch.token_length = word.token_length;
  assign out_ch.last         = word.last;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for sexpr_tokenizer: a directed word table, then random token streams.
module tb;
  import sxt_pkg::*;

  localparam int unsigned IdleTail   = 4;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseWords = 50;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    logic [1:0] n;
    sxt_res_t   r0;
    sxt_res_t   r1;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;

  sxt_in_if  in_ch ();
  sxt_out_if out_ch ();

  sexpr_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic [1:0]      tok_mode = MODE_SKIP;
  logic [LenW-1:0] tok_count = '0;
  logic [LenW-1:0] max_len_shadow = MaxLenReset;
  logic [LenW-1:0] phase_len [7] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd5, MaxLenReset};

  sxt_res_t  step_words[$];
  sxt_res_t  pending_words[$];
  stim_row_t dir_rows[$];
  sxt_res_t  got_word;
  sxt_res_t  want_word;

  int   words_counted = 0;
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   rx_hold_cycles = 0;
  int   result_index = 0;
  logic tx_burst = 1'b0;
  logic tx_force_burst = 1'b0;
  logic rx_burst = 1'b0;

  always #4 clk = ~clk;

  function automatic logic is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_CR || b == CH_LF || b == CH_TAB;
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return is_blank(b) || b == CH_OPEN || b == CH_CLOSE || b == CH_QUOTE;
  endfunction

  function automatic sxt_res_t res_word(logic [2:0] kind, logic [7:0] b,
                                        logic [LenW-1:0] len, logic last);
    sxt_res_t w;
    w.kind = kind;
    w.content_byte = b;
    w.token_length = len;
    w.last = last;
    return w;
  endfunction

  function automatic stim_row_t p_row(logic [7:0] b, logic eoi);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.eoi = eoi;
    return r;
  endfunction

  function automatic stim_row_t t_row(logic [7:0] b, logic eoi, logic [1:0] n,
                                      sxt_res_t r0, sxt_res_t r1);
    stim_row_t r;
    r = p_row(b, eoi);
    r.typed = 1'b1;
    r.n = n;
    r.r0 = r0;
    r.r1 = r1;
    return r;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_CR;
      2: return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic logic [7:0] token_byte(logic in_string);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (in_string ? (b == CH_QUOTE) : is_delim(b));
    return b;
  endfunction

  task automatic keep_content(input logic [7:0] b);
    logic [LenW-1:0] lim;
    lim = (max_len_shadow != '0) ? max_len_shadow - 16'd1 : '0;
    if (tok_count < lim) begin
      tok_count = tok_count + 16'd1;
      step_words.push_back(res_word(KIND_CONTENT, b, '0, 1'b0));
    end
  endtask

  task automatic skip_byte(input logic [7:0] b);
    if (is_blank(b)) begin
    end else if (b == CH_OPEN) begin
      step_words.push_back(res_word(KIND_BEGIN, 8'h00, '0, 1'b0));
    end else if (b == CH_CLOSE) begin
      step_words.push_back(res_word(KIND_END, 8'h00, '0, 1'b0));
    end else begin
      tok_count = '0;
      if (b == CH_QUOTE) begin
        tok_mode = MODE_STRING;
      end else begin
        tok_mode = MODE_VALUE;
        keep_content(b);
      end
    end
  endtask

  task automatic tokenize_word(input logic [7:0] b, input logic eoi);
    sxt_res_t w;
    step_words.delete();
    if (eoi) begin
      if (tok_mode == MODE_STRING)
        step_words.push_back(res_word(KIND_STRING_END, 8'h00, tok_count, 1'b0));
      else if (tok_mode == MODE_VALUE)
        step_words.push_back(res_word(KIND_VALUE_END, 8'h00, tok_count, 1'b0));
      else
        step_words.push_back(res_word(KIND_EOI_ERROR, 8'h00, '0, 1'b0));
      tok_mode = MODE_SKIP;
      tok_count = '0;
    end else if (tok_mode == MODE_STRING) begin
      if (b == CH_QUOTE) begin
        step_words.push_back(res_word(KIND_STRING_END, 8'h00, tok_count, 1'b0));
        tok_mode = MODE_SKIP;
        tok_count = '0;
      end else begin
        keep_content(b);
      end
    end else if (tok_mode == MODE_VALUE) begin
      if (is_delim(b)) begin
        step_words.push_back(res_word(KIND_VALUE_END, 8'h00, tok_count, 1'b0));
        tok_mode = MODE_SKIP;
        tok_count = '0;
        skip_byte(b);
      end else begin
        keep_content(b);
      end
    end else begin
      tok_mode = MODE_SKIP;
      skip_byte(b);
    end
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      w.last = 1'b1;
      step_words[step_words.size() - 1] = w;
    end
  endtask

  task automatic send_word(input stim_row_t row);
    int gap;
    gap = (tx_burst || tx_force_burst) ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0)
      tx_burst = !tx_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= row.b;
    in_ch.end_of_input <= row.eoi;
    do @(posedge clk);
    while (!in_ch.ready);
    if (row.eoi || tok_mode != MODE_SKIP || !is_blank(row.b))
      words_counted++;
    tokenize_word(row.b, row.eoi);
    if (row.typed) begin
      if (row.n > 0)
        pending_words.push_back(row.r0);
      if (row.n > 1)
        pending_words.push_back(row.r1);
    end else begin
      foreach (step_words[i])
        pending_words.push_back(step_words[i]);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (IdleTail) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LenW-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_shadow = value;
  endtask

  task automatic send_random(input int quota);
    int start_count;
    int pick;
    int len;
    start_count = words_counted;
    while (words_counted - start_count < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        send_word(p_row(CH_OPEN, 1'b0));
      end else if (pick < 28) begin
        send_word(p_row(CH_CLOSE, 1'b0));
      end else if (pick < 38) begin
        send_word(p_row(blank_byte(), 1'b0));
      end else if (pick < 62) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send_word(p_row(token_byte(1'b0), 1'b0));
      end else if (pick < 84) begin
        send_word(p_row(CH_QUOTE, 1'b0));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
        for (int k = 0; k < len; k++)
          send_word(p_row(token_byte(1'b1), 1'b0));
        if ($urandom_range(0, 9) != 0)
          send_word(p_row(CH_QUOTE, 1'b0));
      end else if (pick < 90) begin
        send_word(p_row(8'($urandom_range(0, 255)), 1'b1));
      end else begin
        send_word(p_row(8'($urandom_range(0, 255)), 1'b0));
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 12);
      end
      if ($urandom_range(0, 39) == 0)
        rx_burst = !rx_burst;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_word = res_word(out_ch.kind, out_ch.content_byte, out_ch.token_length, out_ch.last);
      if (pending_words.size() == 0) begin
        if (fail_count < 10)
          $display("result %0d unexpected: kind %0d byte %02h len %0d last %0b", result_index,
                   got_word.kind, got_word.content_byte, got_word.token_length, got_word.last);
        fail_count++;
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.kind !== want_word.kind || got_word.content_byte !== want_word.content_byte
            || got_word.token_length !== want_word.token_length
            || got_word.last !== want_word.last) begin
          if (fail_count < 10)
            $display("result %0d mismatch: expected kind %0d byte %02h len %0d last %0b, %s",
                     result_index, want_word.kind, want_word.content_byte,
                     want_word.token_length, want_word.last,
                     $sformatf("got kind %0d byte %02h len %0d last %0b", got_word.kind,
                               got_word.content_byte, got_word.token_length, got_word.last));
          fail_count++;
        end
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;

    dir_rows.push_back(t_row(8'h00, 1'b1, 2'd1, res_word(KIND_EOI_ERROR, 8'h00, '0, 1'b1), '0));
    dir_rows.push_back(t_row(CH_OPEN, 1'b0, 2'd1, res_word(KIND_BEGIN, 8'h00, '0, 1'b1), '0));
    dir_rows.push_back(t_row(CH_CLOSE, 1'b0, 2'd1, res_word(KIND_END, 8'h00, '0, 1'b1), '0));
    dir_rows.push_back(t_row(CH_SPACE, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(t_row(CH_TAB, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(t_row(CH_CR, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(t_row(8'hFF, 1'b0, 2'd1, res_word(KIND_CONTENT, 8'hFF, '0, 1'b1), '0));
    dir_rows.push_back(p_row(8'h80, 1'b0));
    dir_rows.push_back(p_row(CH_CLOSE, 1'b0));
    dir_rows.push_back(t_row(CH_QUOTE, 1'b0, 2'd0, '0, '0));
    dir_rows.push_back(t_row(8'h00, 1'b0, 2'd1, res_word(KIND_CONTENT, 8'h00, '0, 1'b1), '0));
    dir_rows.push_back(t_row(CH_OPEN, 1'b0, 2'd1, res_word(KIND_CONTENT, CH_OPEN, '0, 1'b1), '0));
    dir_rows.push_back(p_row(8'hFF, 1'b0));
    dir_rows.push_back(p_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(p_row(8'h61, 1'b0));
    dir_rows.push_back(p_row(CH_QUOTE, 1'b0));
    dir_rows.push_back(p_row(CH_SPACE, 1'b0));
    dir_rows.push_back(p_row(8'hA5, 1'b1));
    dir_rows.push_back(p_row(8'h78, 1'b0));
    dir_rows.push_back(p_row(CH_OPEN, 1'b0));
    dir_rows.push_back(p_row(8'h79, 1'b0));
    dir_rows.push_back(p_row(CH_LF, 1'b0));
    dir_rows.push_back(p_row(8'h7A, 1'b0));
    dir_rows.push_back(p_row(8'h00, 1'b1));
    dir_rows.push_back(t_row(8'hFF, 1'b1, 2'd1, res_word(KIND_EOI_ERROR, 8'h00, '0, 1'b1), '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i]);

    foreach (phase_len[ph]) begin
      write_max_len(phase_len[ph]);
      if (ph == 1) begin
        tx_force_burst = 1'b1;
        rx_hold_cycles = HoldCycles;
      end
      send_random(PhaseWords);
      tx_force_burst = 1'b0;
      if (ph % 2 == 0)
        wait_idle();
      send_random(PhaseWords);
    end

    wait_idle();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
